// ----- src/ycbcr420sp_to_bgr_converter_core_assert.svh -----
// Assertion macros shared by the converter RTL.
`ifndef YCBCR420SP_TO_BGR_CONVERTER_CORE_ASSERT_SVH
`define YCBCR420SP_TO_BGR_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define YCB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define YCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- src/ycb2bgr_pkg.sv -----
// Types, constants and helpers of the YCbCr 4:2:0 to BGR converter.
package ycb2bgr_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int CNT_W    = $clog2(MAX_DIM);
    localparam int DIM_W    = 13;
    localparam int CHROMA_W = 9;
    localparam int FIX      = 10;
    localparam int SUM_W    = 21;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [CHROMA_W-1:0] t_chroma;

    localparam t_sum COEF_CR_R = t_sum'(1437);
    localparam t_sum COEF_CR_G = t_sum'(731);
    localparam t_sum COEF_CB_G = t_sum'(352);
    localparam t_sum COEF_CB_B = t_sum'(1816);
    localparam t_chroma CHROMA_OFS = t_chroma'(128);

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb_raw;
        logic [7:0] cr_raw;
    } t_in_word;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       row_end;
        logic       frame_end;
    } t_out_word;

    // Last counter position for a programmed dimension; zero acts as one and
    // anything above the maximum acts as the maximum.
    function automatic logic [CNT_W-1:0] last_pos(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (v > DIM_W'(MAX_DIM)) begin
            return CNT_W'(MAX_DIM - 1);
        end else begin
            return CNT_W'(v - 1'b1);
        end
    endfunction

endpackage

// ----- src/ycbcr420sp_to_bgr_converter_core.sv -----
// Top level of the YCbCr 4:2:0 semi-planar to BGR pixel converter.
// One pixel word in and one BGR word out per clock while i_out_ready is high.
// Pipeline: a product register after the chroma multipliers and a result
// register after the add, floor shift and clamp. Chroma is taken from the
// input word at even columns and reused at odd columns. row_end and frame_end
// follow the programmed frame_width and frame_height (index 0 and 1 on the
// configuration port); a zero dimension acts as one and anything above 4096
// acts as 4096. Counters and held chroma are cleared only by reset.
`include "ycbcr420sp_to_bgr_converter_core_assert.svh"

module ycbcr420sp_to_bgr_converter_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ycb2bgr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ycb2bgr_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  ycb2bgr_pkg::t_in_word              i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output ycb2bgr_pkg::t_out_word             o_out_word
);

    logic [ycb2bgr_pkg::CNT_W-1:0] r_col_last;
    logic [ycb2bgr_pkg::CNT_W-1:0] r_row_last;
    logic [ycb2bgr_pkg::CNT_W-1:0] r_col;
    logic [ycb2bgr_pkg::CNT_W-1:0] r_row;
    logic [ycb2bgr_pkg::CNT_W-1:0] n_col;
    logic [ycb2bgr_pkg::CNT_W-1:0] n_row;
    ycb2bgr_pkg::t_chroma          r_held_cb;
    ycb2bgr_pkg::t_chroma          r_held_cr;
    ycb2bgr_pkg::t_chroma          n_held_cb;
    ycb2bgr_pkg::t_chroma          n_held_cr;
    logic                          n_row_end;
    logic                          n_frame_end;

    logic                 r_s1_valid;
    logic [7:0]           r_s1_y;
    ycb2bgr_pkg::t_sum    r_s1_pb;
    ycb2bgr_pkg::t_sum    r_s1_pr;
    ycb2bgr_pkg::t_sum    r_s1_pgr;
    ycb2bgr_pkg::t_sum    r_s1_pgb;
    logic                 r_s1_row_end;
    logic                 r_s1_frame_end;

    logic                   r_out_valid;
    ycb2bgr_pkg::t_out_word r_out_word;

    logic              out_adv;
    logic              in_accept;
    ycb2bgr_pkg::t_sum ys;
    ycb2bgr_pkg::t_sum sum_b;
    ycb2bgr_pkg::t_sum sum_g;
    ycb2bgr_pkg::t_sum sum_r;

    // Floor divide by 1024 and clamp to a byte.
    function automatic logic [7:0] to_channel(input ycb2bgr_pkg::t_sum s);
        logic [ycb2bgr_pkg::SUM_W-ycb2bgr_pkg::FIX-1:0] q;
        q = s[ycb2bgr_pkg::SUM_W-1:ycb2bgr_pkg::FIX];
        if (q[ycb2bgr_pkg::SUM_W-ycb2bgr_pkg::FIX-1]) begin
            return 8'd0;
        end else if (|q[ycb2bgr_pkg::SUM_W-ycb2bgr_pkg::FIX-2:8]) begin
            return 8'd255;
        end else begin
            return q[7:0];
        end
    endfunction

    assign out_adv    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || out_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    // Configuration registers keep the last position, not the raw size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= ycb2bgr_pkg::last_pos(ycb2bgr_pkg::FRAME_WIDTH_RST);
            r_row_last <= ycb2bgr_pkg::last_pos(ycb2bgr_pkg::FRAME_HEIGHT_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ycb2bgr_pkg::CFG_FRAME_WIDTH: begin
                    r_col_last <= ycb2bgr_pkg::last_pos(i_cfg_data);
                end
                ycb2bgr_pkg::CFG_FRAME_HEIGHT: begin
                    r_row_last <= ycb2bgr_pkg::last_pos(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (!r_col[0]) begin
            n_held_cb = ycb2bgr_pkg::t_chroma'({1'b0, i_in_word.cb_raw})
                        - ycb2bgr_pkg::CHROMA_OFS;
            n_held_cr = ycb2bgr_pkg::t_chroma'({1'b0, i_in_word.cr_raw})
                        - ycb2bgr_pkg::CHROMA_OFS;
        end else begin
            n_held_cb = r_held_cb;
            n_held_cr = r_held_cr;
        end
        // A counter past the last position after a shrink still ends the row.
        n_row_end   = r_col >= r_col_last;
        n_frame_end = n_row_end && (r_row >= r_row_last);
        if (n_row_end) begin
            n_col = '0;
            n_row = n_frame_end ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_held_cb <= '0;
            r_held_cr <= '0;
        end else if (in_accept) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_held_cb <= n_held_cb;
            r_held_cr <= n_held_cr;
        end
    end

    // Stage 1: chroma products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_y         <= i_in_word.luma;
            r_s1_pb        <= ycb2bgr_pkg::t_sum'(n_held_cb) * ycb2bgr_pkg::COEF_CB_B;
            r_s1_pr        <= ycb2bgr_pkg::t_sum'(n_held_cr) * ycb2bgr_pkg::COEF_CR_R;
            r_s1_pgr       <= ycb2bgr_pkg::t_sum'(n_held_cr) * ycb2bgr_pkg::COEF_CR_G;
            r_s1_pgb       <= ycb2bgr_pkg::t_sum'(n_held_cb) * ycb2bgr_pkg::COEF_CB_G;
            r_s1_row_end   <= n_row_end;
            r_s1_frame_end <= n_frame_end;
        end
    end

    // Stage 2: luma add, floor shift and clamp.
    always_comb begin
        ys    = ycb2bgr_pkg::t_sum'({1'b0, r_s1_y, {ycb2bgr_pkg::FIX{1'b0}}});
        sum_b = ys + r_s1_pb;
        sum_g = ys - r_s1_pgr - r_s1_pgb;
        sum_r = ys + r_s1_pr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_valid) begin
            r_out_word.blue      <= to_channel(sum_b);
            r_out_word.green     <= to_channel(sum_g);
            r_out_word.red       <= to_channel(sum_r);
            r_out_word.row_end   <= r_s1_row_end;
            r_out_word.frame_end <= r_s1_frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `YCB_ASSERT_IMPL(a_frame_end_in_row_end, i_clk, i_rst_n,
        o_out_valid && o_out_word.frame_end, o_out_word.row_end)
    `YCB_ASSERT_NEXT(a_col_wraps, i_clk, i_rst_n,
        in_accept && n_row_end, r_col == '0)
    `YCB_ASSERT_NEXT(a_col_steps, i_clk, i_rst_n,
        in_accept && !n_row_end, r_col == $past(r_col) + 1'b1)
    `YCB_ASSERT_NEXT(a_s1_holds_on_stall, i_clk, i_rst_n,
        r_s1_valid && !out_adv, r_s1_valid && $stable(r_s1_y))

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the YCbCr 4:2:0 to BGR pixel converter.
`timescale 1ns / 100ps

module tb;
    import ycb2bgr_pkg::*;

    localparam int K_CR_R      = 1437;
    localparam int K_CR_G      = 731;
    localparam int K_CB_G      = 352;
    localparam int K_CB_B      = 1816;
    localparam int CHROMA_BIAS = 128;
    localparam int Q_SHIFT     = 10;
    localparam int BYTE_MAX    = 255;
    localparam int MAX_SHOWN   = 10;

    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [DIM_W-1:0]       data;
        t_in_word               px;
        logic                   typed_ok;
        t_out_word              res;
    } plan_row_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [15:0]      count;
        idle_mode_e       mode;
    } phase_t;

    localparam int N_DIRECTED = 28;
    localparam plan_row_t DIRECTED [N_DIRECTED] = '{
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd0, 8'd128, 8'd128}, 1'b1,
          '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}},
        // Odd column: the pair in the word is ignored, the neutral pair is reused.
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd255, 8'd0, 8'd0}, 1'b1,
          '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd0, 8'd0, 8'd0}, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd0, 8'd0, 8'd0}, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd255, 8'd0, 8'd0}, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd128, 8'd0, 8'd255}, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd128, 8'd255, 8'd0}, 1'b0, '0},
        // Zero dimensions act as one; the column counter is past the new end.
        '{ROW_REG, CFG_FRAME_WIDTH, 13'd0, '0, 1'b0, '0},
        '{ROW_REG, CFG_FRAME_HEIGHT, 13'd0, '0, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd255, 8'd128, 8'd128}, 1'b1,
          '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1}},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd0, 8'd128, 8'd128}, 1'b1,
          '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1}},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd255, 8'd255, 8'd0}, 1'b0, '0},
        '{ROW_REG, CFG_FRAME_WIDTH, 13'd2, '0, 1'b0, '0},
        '{ROW_REG, CFG_FRAME_HEIGHT, 13'd2, '0, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd200, 8'd100, 8'd50}, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd10, 8'd60, 8'd250}, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd90, 8'd30, 8'd170}, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd255, 8'd1, 8'd254}, 1'b0, '0},
        // Oversize dimensions act as the maximum.
        '{ROW_REG, CFG_FRAME_WIDTH, 13'd8191, '0, 1'b0, '0},
        '{ROW_REG, CFG_FRAME_HEIGHT, 13'd8191, '0, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd17, 8'd240, 8'd16}, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd0, 8'd0, 8'd0}, 1'b0, '0},
        '{ROW_REG, CFG_FRAME_WIDTH, 13'd3, '0, 1'b0, '0},
        '{ROW_REG, CFG_FRAME_HEIGHT, 13'd1, '0, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd128, 8'd128, 8'd0}, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd1, 8'd2, 8'd3}, 1'b0, '0},
        '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, '{8'd254, 8'd253, 8'd252}, 1'b0, '0}
    };

    localparam int N_PHASES = 11;
    localparam phase_t PHASES [N_PHASES] = '{
        '{13'd1,    13'd1,    16'd60,  IDLE_NONE},
        '{13'd2,    13'd2,    16'd100, IDLE_SEND},
        '{13'd3,    13'd5,    16'd120, IDLE_RECV},
        '{13'd5,    13'd3,    16'd120, IDLE_BOTH},
        '{13'd16,   13'd9,    16'd200, IDLE_NONE},
        '{13'd7,    13'd1,    16'd100, IDLE_SEND},
        '{13'd640,  13'd480,  16'd80,  IDLE_RECV},
        '{13'd4096, 13'd2,    16'd60,  IDLE_BOTH},
        '{13'd8191, 13'd0,    16'd30,  IDLE_NONE},
        '{13'd0,    13'd4096, 16'd60,  IDLE_SEND},
        '{13'd33,   13'd4,    16'd220, IDLE_RECV}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [DIM_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_word             o_out_word;

    // Predictor state, mirroring the block's counters and held chroma.
    logic [DIM_W-1:0] frame_w;
    logic [DIM_W-1:0] frame_h;
    int               px_col;
    int               px_row;
    int               chroma_cb;
    int               chroma_cr;

    t_out_word bgr_expected[$];
    int        send_idle_pct;
    int        stall_pct;
    int        pixels_sent;
    int        results_seen;
    int        row_ends_seen;
    int        frame_ends_seen;
    int        mismatches;

    ycbcr420sp_to_bgr_converter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return 1;
        end else if (v > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    // Floor division by 1024 through the arithmetic shift, then saturate.
    function automatic logic [7:0] q10_to_byte(input int v);
        int q;
        q = v >>> Q_SHIFT;
        if (q < 0) begin
            return 8'd0;
        end else if (q > BYTE_MAX) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    function automatic t_out_word convert_pixel(input t_in_word px);
        int        w_eff;
        int        h_eff;
        int        ys;
        t_out_word r;
        w_eff = eff_dim(frame_w);
        h_eff = eff_dim(frame_h);
        if (px_col[0] == 1'b0) begin
            chroma_cb = int'(px.cb_raw) - CHROMA_BIAS;
            chroma_cr = int'(px.cr_raw) - CHROMA_BIAS;
        end
        ys = int'(px.luma) << Q_SHIFT;
        r.blue      = q10_to_byte(ys + K_CB_B * chroma_cb);
        r.green     = q10_to_byte(ys - K_CR_G * chroma_cr - K_CB_G * chroma_cb);
        r.red       = q10_to_byte(ys + K_CR_R * chroma_cr);
        r.row_end   = (px_col >= w_eff - 1);
        r.frame_end = 1'b0;
        if (r.row_end) begin
            px_col = 0;
            r.frame_end = (px_row >= h_eff - 1);
            px_row = r.frame_end ? 0 : px_row + 1;
        end else begin
            px_col++;
        end
        return r;
    endfunction

    // Extreme bytes are favored so the clamps and the chroma limits get hit often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd128;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic set_idle(input idle_mode_e mode);
        send_idle_pct = (mode == IDLE_SEND) ? 65 : (mode == IDLE_BOTH) ? 25 : 0;
        stall_pct     = (mode == IDLE_RECV) ? 65 : (mode == IDLE_BOTH) ? 25 : 0;
    endtask

    task automatic push_pixel(input t_in_word px, input logic typed_ok,
                              input t_out_word typed_res, input bit drain_first);
        t_out_word predicted;
        if (drain_first) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (bgr_expected.size() != 0);
        end else begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_word  <= px;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = convert_pixel(px);
        bgr_expected.push_back(typed_ok ? typed_res : predicted);
        pixels_sent++;
    endtask

    // Registers change only with the pipeline empty and settled.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (bgr_expected.size() != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) begin
            frame_w = val;
        end else begin
            frame_h = val;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            row_ends_seen   += o_out_word.row_end;
            frame_ends_seen += o_out_word.frame_end;
            if (bgr_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("%0t: output word with nothing pending: %p", $realtime, o_out_word);
                end
            end else begin
                want = bgr_expected.pop_front();
                if (o_out_word.blue !== want.blue || o_out_word.green !== want.green ||
                    o_out_word.red !== want.red || o_out_word.row_end !== want.row_end ||
                    o_out_word.frame_end !== want.frame_end) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("%0t: word %0d expected b=%0d g=%0d r=%0d re=%b fe=%b",
                                 $realtime, results_seen, want.blue, want.green, want.red,
                                 want.row_end, want.frame_end);
                        $display("%0t: word %0d got      b=%0d g=%0d r=%0d re=%b fe=%b",
                                 $realtime, results_seen, o_out_word.blue, o_out_word.green,
                                 o_out_word.red, o_out_word.row_end, o_out_word.frame_end);
                    end
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("timeout with %0d words still pending", bgr_expected.size());
        $display("[ycbcr420sp_to_bgr_converter_core] ERROR");
        $finish;
    end

    initial begin
        int       pause_at;
        t_in_word px;
        frame_w         = FRAME_WIDTH_RST;
        frame_h         = FRAME_HEIGHT_RST;
        px_col          = 0;
        px_row          = 0;
        chroma_cb       = 0;
        chroma_cr       = 0;
        pixels_sent     = 0;
        results_seen    = 0;
        row_ends_seen   = 0;
        frame_ends_seen = 0;
        mismatches      = 0;
        set_idle(IDLE_NONE);
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_FRAME_WIDTH;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_out_ready <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[n]) begin
            if (DIRECTED[n].kind == ROW_REG) begin
                write_reg(DIRECTED[n].idx, DIRECTED[n].data);
            end else begin
                push_pixel(DIRECTED[n].px, DIRECTED[n].typed_ok, DIRECTED[n].res, 1'b0);
            end
        end

        foreach (PHASES[p]) begin
            set_idle(PHASES[p].mode);
            write_reg(CFG_FRAME_WIDTH, PHASES[p].width);
            write_reg(CFG_FRAME_HEIGHT, PHASES[p].height);
            pause_at = $urandom_range(int'(PHASES[p].count) - 1);
            for (int k = 0; k < int'(PHASES[p].count); k++) begin
                px.luma   = pick_byte();
                px.cb_raw = pick_byte();
                px.cr_raw = pick_byte();
                push_pixel(px, 1'b0, '0, k == pause_at);
            end
        end

        i_in_valid <= 1'b0;
        set_idle(IDLE_NONE);
        while (bgr_expected.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d pixels over %0d frame geometries, checked %0d BGR words.",
                 pixels_sent, N_PHASES, results_seen);
        $display("Saw %0d row ends and %0d frame ends; %0d mismatches.",
                 row_ends_seen, frame_ends_seen, mismatches);
        if (mismatches == 0) begin
            $display("[ycbcr420sp_to_bgr_converter_core] OK");
        end else begin
            $display("[ycbcr420sp_to_bgr_converter_core] ERROR");
        end
        $finish;
    end

endmodule
